// File: src/cluster_light_sphere_cull_defines.svh
// Assertion macros for the cluster light sphere cull block.
// Included by the top level; depends on nothing else.
`ifndef CLUSTER_LIGHT_SPHERE_CULL_DEFINES_SVH
`define CLUSTER_LIGHT_SPHERE_CULL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLCULL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLCULL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/clcull_pkg.sv
// Shared types and constants for the cluster light sphere cull block.
// Used by the plane memory, the plane evaluator and the top level.
`default_nettype none

package clcull_pkg;

  localparam int unsigned PlanesPerCluster = 6;
  localparam int unsigned MaxClustersDef   = 8192;
  localparam int unsigned ClusterW         = 13;
  localparam int unsigned SlotW            = 3;
  localparam int unsigned ValueW           = 32;
  localparam int unsigned RadiusW          = 31;
  localparam int unsigned R2W              = 2 * RadiusW;
  localparam int unsigned IdxW             = 16;

  localparam logic [RadiusW-1:0] RadiusReset = 31'd1638400;
  localparam logic [R2W-1:0]     R2Reset     = R2W'(RadiusReset) * R2W'(RadiusReset);

  localparam logic OpWrite = 1'b0;
  localparam logic OpTest  = 1'b1;

  typedef struct packed {
    logic signed [ValueW-1:0] nx;
    logic signed [ValueW-1:0] ny;
    logic signed [ValueW-1:0] nz;
    logic signed [ValueW-1:0] w;
  } plane_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic cull;
  } eval_out_t;

endpackage

`default_nettype wire

// File: src/clcull_plane_mem.sv
// Plane table: one synchronous memory holding all four plane coefficients.
// One write port and one read port with registered read data; uses clcull_pkg.
`default_nettype none

module clcull_plane_mem #(
  parameter int unsigned DEPTH = clcull_pkg::MaxClustersDef * clcull_pkg::PlanesPerCluster,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrW-1:0]    waddr_i,
  input  wire clcull_pkg::plane_t  wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrW-1:0]    raddr_i,
  output clcull_pkg::plane_t       rdata_o
);

  clcull_pkg::plane_t mem_q [DEPTH];
  clcull_pkg::plane_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/clcull_plane_eval.sv
// Pipelined plane test: signed distance, squared norm and the exact square
// compare, one plane per cycle over five register stages; uses clcull_pkg.
`default_nettype none

module clcull_plane_eval (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire clcull_pkg::plane_t                  plane_i,
  input  wire clcull_pkg::tag_t                    tag_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0] lx_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0] ly_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0] lz_i,
  input  wire logic [clcull_pkg::R2W-1:0]          r2_i,
  output clcull_pkg::eval_out_t                    out_o
);

  clcull_pkg::tag_t tag_a_q, tag_b_q, tag_c_q, tag_d_q, tag_e_q;

  logic signed [63:0] dx_d, dy_d, dz_d, sx_d, sy_d, sz_d;
  logic signed [63:0] dx_q, dy_q, dz_q;
  logic [63:0]        sx_q, sy_q, sz_q;
  logic signed [31:0] w_q;

  logic signed [65:0] s_d, s_q;
  logic [63:0]        n2_b_q;

  logic [63:0] mag_q, n2_c_q;
  logic        neg_c_q;

  logic [63:0] mm_ll_q, mm_lh_q, mm_hh_q;
  logic [63:0] rn_ll_q, rn_lh_q, rn_hl_q, rn_hh_q;
  logic        neg_d_q;

  logic [127:0] mm_d, rn_d, mm_q, rn_q;
  logic         neg_e_q;

  always_comb begin
    dx_d = plane_i.nx * lx_i;
    dy_d = plane_i.ny * ly_i;
    dz_d = plane_i.nz * lz_i;
    sx_d = plane_i.nx * plane_i.nx;
    sy_d = plane_i.ny * plane_i.ny;
    sz_d = plane_i.nz * plane_i.nz;
  end

  assign s_d = 66'(dx_q) + 66'(dy_q) + 66'(dz_q) + (66'(w_q) <<< 16);

  assign mm_d = {mm_hh_q, mm_ll_q} + (128'(mm_lh_q) << 33);
  assign rn_d = {rn_hh_q, rn_ll_q} + (128'(rn_lh_q) << 32) + (128'(rn_hl_q) << 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
      tag_d_q <= '0;
      tag_e_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
      tag_d_q <= tag_c_q;
      tag_e_q <= tag_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    dz_q    <= dz_d;
    sx_q    <= $unsigned(sx_d);
    sy_q    <= $unsigned(sy_d);
    sz_q    <= $unsigned(sz_d);
    w_q     <= plane_i.w;

    s_q     <= s_d;
    n2_b_q  <= sx_q + sy_q + sz_q;

    mag_q   <= 64'(-s_q);
    neg_c_q <= s_q[65];
    n2_c_q  <= n2_b_q;

    mm_ll_q <= mag_q[31:0] * mag_q[31:0];
    mm_lh_q <= mag_q[31:0] * mag_q[63:32];
    mm_hh_q <= mag_q[63:32] * mag_q[63:32];
    rn_ll_q <= r2_i[31:0] * n2_c_q[31:0];
    rn_lh_q <= r2_i[31:0] * n2_c_q[63:32];
    rn_hl_q <= 64'(r2_i[clcull_pkg::R2W-1:32]) * 64'(n2_c_q[31:0]);
    rn_hh_q <= 64'(r2_i[clcull_pkg::R2W-1:32]) * 64'(n2_c_q[63:32]);
    neg_d_q <= neg_c_q;

    mm_q    <= mm_d;
    rn_q    <= rn_d;
    neg_e_q <= neg_d_q;
  end

  assign out_o.valid = tag_e_q.valid;
  assign out_o.last  = tag_e_q.last;
  assign out_o.cull  = neg_e_q && (mm_q > rn_q);

endmodule

`default_nettype wire

// File: src/cluster_light_sphere_cull.sv
// Cluster light sphere cull: plane table writes and light-versus-cluster tests.
// A write or an out-of-range test gives its result in the cycle after acceptance, one per cycle.
// An in-range test issues six plane reads, one per cycle, through the registered-read plane memory
// and a five-stage evaluator; the block stays busy, taking no new request, until its result is out.
// Reset sets the radius to 25.0 and idles the control; the plane memory is not cleared.
`default_nettype none

`include "cluster_light_sphere_cull_defines.svh"

module cluster_light_sphere_cull #(
  parameter int unsigned MAX_CLUSTERS = clcull_pkg::MaxClustersDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output wire logic                                  busy,
  input  wire logic                                  opcode_i,
  input  wire logic [clcull_pkg::ClusterW-1:0]       cluster_index_i,
  input  wire logic [clcull_pkg::SlotW-1:0]          plane_slot_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0]  value_x_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0]  value_y_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0]  value_z_i,
  input  wire logic signed [clcull_pkg::ValueW-1:0]  value_w_i,
  input  wire logic                                  cfg_valid_i,
  output wire logic                                  cfg_ready_o,
  input  wire logic [clcull_pkg::RadiusW-1:0]        cfg_data_i,
  output wire logic                                  done_o,
  output wire logic                                  intersects_o,
  output wire logic                                  was_test_o
);

  localparam int unsigned Depth = MAX_CLUSTERS * clcull_pkg::PlanesPerCluster;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [1:0] {StIdle, StIssue, StDrain} state_e;

  state_e state_q;
  logic [2:0] cnt_q;
  logic [AddrW-1:0] addr_q;
  logic signed [clcull_pkg::ValueW-1:0] lx_q, ly_q, lz_q;
  logic [clcull_pkg::RadiusW-1:0] radius_q;
  logic [clcull_pkg::R2W-1:0] r2_q;
  logic acc_q, done_q, intersects_q, was_test_q;
  clcull_pkg::tag_t rd_tag_q, issue_tag;

  logic accept, in_range, is_test, start_test, mem_we, mem_re;
  logic [clcull_pkg::IdxW-1:0] base_full, widx_full;
  logic [AddrW-1:0] base_addr, waddr;
  clcull_pkg::plane_t wdata, rdata;
  clcull_pkg::eval_out_t eval_out;

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign is_test     = (opcode_i == clcull_pkg::OpTest);
  assign in_range    = (32'(cluster_index_i) < MAX_CLUSTERS);
  assign start_test  = accept && is_test && in_range;

  assign base_full = (clcull_pkg::IdxW'(cluster_index_i) << 2)
                   + (clcull_pkg::IdxW'(cluster_index_i) << 1);
  assign widx_full = base_full + clcull_pkg::IdxW'(plane_slot_i);
  assign base_addr = AddrW'(base_full);
  assign waddr     = AddrW'(widx_full);

  assign mem_we = accept && !is_test && in_range
               && (32'(plane_slot_i) < clcull_pkg::PlanesPerCluster);
  assign wdata  = '{nx: value_x_i, ny: value_y_i, nz: value_z_i, w: value_w_i};
  assign mem_re = (state_q == StIssue);

  assign issue_tag.valid = mem_re;
  assign issue_tag.last  = (cnt_q == 3'(clcull_pkg::PlanesPerCluster - 1));

  clcull_plane_mem #(
    .DEPTH (Depth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  clcull_plane_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .plane_i (rdata),
    .tag_i   (rd_tag_q),
    .lx_i    (lx_q),
    .ly_i    (ly_q),
    .lz_i    (lz_q),
    .r2_i    (r2_q),
    .out_o   (eval_out)
  );

  always_ff @(posedge clk_i) begin
    if (start_test) begin
      lx_q <= value_x_i;
      ly_q <= value_y_i;
      lz_q <= value_z_i;
      addr_q <= base_addr;
    end else if (mem_re) begin
      addr_q <= addr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      acc_q        <= 1'b0;
      done_q       <= 1'b0;
      intersects_q <= 1'b0;
      was_test_q   <= 1'b0;
      rd_tag_q     <= '0;
      radius_q     <= clcull_pkg::RadiusReset;
      r2_q         <= clcull_pkg::R2Reset;
    end else begin
      done_q   <= 1'b0;
      rd_tag_q <= issue_tag;
      r2_q     <= clcull_pkg::R2W'(radius_q) * clcull_pkg::R2W'(radius_q);
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
      if (eval_out.valid) begin
        acc_q <= acc_q | eval_out.cull;
      end
      unique case (state_q)
        StIdle: begin
          if (start_test) begin
            state_q <= StIssue;
            cnt_q   <= '0;
            acc_q   <= 1'b0;
          end else if (accept) begin
            done_q       <= 1'b1;
            intersects_q <= 1'b0;
            was_test_q   <= is_test;
          end
        end
        StIssue: begin
          cnt_q <= cnt_q + 3'd1;
          if (issue_tag.last) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (eval_out.valid && eval_out.last) begin
            done_q       <= 1'b1;
            intersects_q <= !(acc_q || eval_out.cull);
            was_test_q   <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign intersects_o = intersects_q;
  assign was_test_o   = was_test_q;

  `CLCULL_ASSERT_IMP(a_done_when_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  `CLCULL_ASSERT_NEXT(a_test_goes_busy, clk_i, rst_ni, start_test, busy, "test not started")
  `CLCULL_ASSERT_IMP(a_eval_only_busy, clk_i, rst_ni, eval_out.valid, busy, "stray plane result")
  `CLCULL_ASSERT_IMP(a_done_has_cause, clk_i, rst_ni, done_o, $past(accept | busy), "stray result")

endmodule

`default_nettype wire
